>>> hdl/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types, codes and helpers for the counting semaphore with a FIFO of
// waiting requesters.
// ----------------------------------------------------------------------------
package csfw_pkg;

    // Request types
    localparam logic [1:0] REQ_ACQUIRE = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_CANCEL  = 2'd2;
    localparam logic [1:0] REQ_DELETE  = 2'd3;

    // Result status codes
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_BAD_VALUE   = 3'd1;
    localparam logic [2:0] STATUS_WOULD_BLOCK = 3'd2;
    localparam logic [2:0] STATUS_TIMED_OUT   = 3'd3;
    localparam logic [2:0] STATUS_DELETED     = 3'd4;
    localparam logic [2:0] STATUS_QUEUE_FULL  = 3'd5;

    // Register word index (paddr[2])
    localparam logic REG_INITIAL_COUNT = 1'b0;

    // Request transaction payload
    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  requester_id;
        logic [15:0] amount;
        logic        no_wait;
    } req_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [3:0] target_id;
        logic [2:0] status;
        logic       last;
    } rsp_item_t;

    // Per-cell controls of the waiter chain
    typedef struct packed {
        logic shift;   // take the neighbor's entry
        logic load;    // take the broadcast entry (wins over shift)
    } cell_ctl_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_RESERVE,
        ST_NOTIFY,
        ST_GRANT,
        ST_DELETE
    } state_t;

    // Clamp a 34-bit signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -34'sh0_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/csfw_cell.sv
// ----------------------------------------------------------------------------
// csfw_cell
// One slot of the waiter queue: holds a requester id and its amount, and
// either shifts in its tail-side neighbor or loads a broadcast entry.
// ----------------------------------------------------------------------------
module csfw_cell #(
    parameter int AMT_W = 16
) (
    input  logic                 clk,
    input  csfw_pkg::cell_ctl_t  ctl,
    input  logic [3:0]           load_id,
    input  logic [AMT_W-1:0]     load_amt,
    input  logic [3:0]           next_id,
    input  logic [AMT_W-1:0]     next_amt,
    output logic [3:0]           id,
    output logic [AMT_W-1:0]     amt
);

    logic [3:0]       id_reg;
    logic [AMT_W-1:0] amt_reg;

    // Entry storage, payload only
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            id_reg  <= load_id;
            amt_reg <= load_amt;
        end
        else if (ctl.shift)
        begin
            id_reg  <= next_id;
            amt_reg <= next_amt;
        end
    end

    assign id  = id_reg;
    assign amt = amt_reg;

endmodule

>>> hdl/counting_semaphore_fifo_waiters.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a first-in-first-out queue of waiting requesters.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. Acquire, a rejected request, or any
// request after delete answers at once; a queued acquire answers nothing.
// Release grants head waiters, then answers the releaser. Cancel rotates the
// queue through its head cell one slot per cycle to find the requester; when
// the head is removed, it returns its reservation, reserves for the new head,
// answers, then grants waiters. Delete fails every waiter, then answers. All
// results pass the single output register, so a slow result consumer stalls
// the block. Waiter entries shift one cell per cycle unless stalled; only the
// head cell and the one behind it are examined.
module counting_semaphore_fifo_waiters #(
    parameter int MAX_WAITERS = 16,
    parameter int AMOUNT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // requests
    input  logic                 req_valid,
    output logic                 req_ready,
    input  csfw_pkg::req_item_t  req,
    // results
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output csfw_pkg::rsp_item_t  rsp
);

    localparam int AMT_W    = (AMOUNT_BITS < 16) ? AMOUNT_BITS : 16;
    localparam int CNT_W    = $clog2(MAX_WAITERS + 1);
    localparam int IDX_W    = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int NEXT_IDX = (MAX_WAITERS > 1) ? 1 : 0;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_WAITERS);
    localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

    // Waiter chain
    logic [3:0]          cell_id  [MAX_WAITERS];
    logic [AMT_W-1:0]    cell_amt [MAX_WAITERS];
    csfw_pkg::cell_ctl_t cell_ctl [MAX_WAITERS];

    logic             shift_en;
    logic             load_en;
    logic [IDX_W-1:0] load_idx;
    logic [3:0]       load_id;
    logic [AMT_W-1:0] load_amt;

    genvar j;
    generate
        for (j = 0; j < MAX_WAITERS; j++)
        begin : g_cell
            logic [3:0]       nb_id;
            logic [AMT_W-1:0] nb_amt;

            if (j + 1 < MAX_WAITERS)
            begin : g_mid
                assign nb_id  = cell_id[j+1];
                assign nb_amt = cell_amt[j+1];
            end
            else
            begin : g_end
                assign nb_id  = cell_id[j];
                assign nb_amt = cell_amt[j];
            end

            assign cell_ctl[j].shift = shift_en;
            assign cell_ctl[j].load  = load_en && (load_idx == IDX_W'(j));

            csfw_cell #(
                .AMT_W (AMT_W)
            ) u_cell (
                .clk      (clk),
                .ctl      (cell_ctl[j]),
                .load_id  (load_id),
                .load_amt (load_amt),
                .next_id  (nb_id),
                .next_amt (nb_amt),
                .id       (cell_id[j]),
                .amt      (cell_amt[j])
            );
        end
    endgenerate

    // Control and count registers
    csfw_pkg::state_t    state_reg, state_next;
    logic signed [31:0]  avail_reg, avail_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                deleted_reg, deleted_next;
    logic [15:0]         init_reg, init_next;
    logic [3:0]          id_reg, id_next;
    logic [AMT_W-1:0]    held_reg, held_next;
    logic [CNT_W-1:0]    scan_left_reg, scan_left_next;
    logic                found_reg, found_next;
    logic                head_gone_reg, head_gone_next;
    logic                first_reg, first_next;
    logic                final_reg, final_next;
    logic                rsp_valid_reg, rsp_valid_next;
    csfw_pkg::rsp_item_t rsp_reg, rsp_next;

    // Datapath terms
    logic                out_free;
    logic                req_fire;
    logic                cfg_wr;
    logic [AMT_W-1:0]    req_amt;
    logic signed [33:0]  avail_sx;
    logic [33:0]         req_amt_ext;
    logic [33:0]         head_amt_ext;
    logic [33:0]         next_amt_ext;
    logic [33:0]         held_ext;
    logic                acq_fits;
    logic signed [31:0]  avail_plus_req;
    logic signed [31:0]  avail_minus_req;
    logic signed [31:0]  avail_minus_head;
    logic signed [31:0]  avail_minus_next;
    logic signed [31:0]  avail_plus_held;
    logic signed [31:0]  after_grant_avail;
    logic                grant_ok;
    logic                more_grants;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == csfw_pkg::ST_IDLE) && out_free;
    assign req_fire  = req_valid && req_ready;
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == csfw_pkg::REG_INITIAL_COUNT);

    assign req_amt      = req.amount[AMT_W-1:0];
    assign avail_sx     = {{2{avail_reg[31]}}, avail_reg};
    assign req_amt_ext  = {{(34-AMT_W){1'b0}}, req_amt};
    assign head_amt_ext = {{(34-AMT_W){1'b0}}, cell_amt[0]};
    assign next_amt_ext = {{(34-AMT_W){1'b0}}, cell_amt[NEXT_IDX]};
    assign held_ext     = {{(34-AMT_W){1'b0}}, held_reg};

    assign acq_fits         = $signed(req_amt_ext) <= avail_sx;
    assign avail_plus_req   = csfw_pkg::sat32(avail_sx + $signed(req_amt_ext));
    assign avail_minus_req  = csfw_pkg::sat32(avail_sx - $signed(req_amt_ext));
    assign avail_minus_head = csfw_pkg::sat32(avail_sx - $signed(head_amt_ext));
    assign avail_minus_next = csfw_pkg::sat32(avail_sx - $signed(next_amt_ext));
    assign avail_plus_held  = csfw_pkg::sat32(avail_sx + $signed(held_ext));

    // Head grant and the reservation of the waiter behind it
    assign grant_ok          = !avail_reg[31] && (total_reg != '0);
    assign after_grant_avail = (total_reg > ONE_COUNT) ? avail_minus_next : avail_reg;
    assign more_grants       = (total_reg > ONE_COUNT) && !after_grant_avail[31];

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        avail_next     = avail_reg;
        total_next     = total_reg;
        deleted_next   = deleted_reg;
        init_next      = init_reg;
        id_next        = id_reg;
        held_next      = held_reg;
        scan_left_next = scan_left_reg;
        found_next     = found_reg;
        head_gone_next = head_gone_reg;
        first_next     = first_reg;
        final_next     = final_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        shift_en       = 1'b0;
        load_en        = 1'b0;
        load_idx       = IDX_W'(total_reg);
        load_id        = req.requester_id;
        load_amt       = req_amt;

        unique case (state_reg)
            csfw_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    id_next = req.requester_id;
                    rsp_next.target_id = req.requester_id;
                    rsp_next.last      = 1'b1;
                    if (deleted_reg)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_next.status = csfw_pkg::STATUS_DELETED;
                    end
                    else
                    begin
                        unique case (req.req_type)
                            csfw_pkg::REQ_ACQUIRE:
                            begin
                                if (req_amt == '0)
                                begin
                                    rsp_valid_next  = 1'b1;
                                    rsp_next.status = csfw_pkg::STATUS_BAD_VALUE;
                                end
                                else if (acq_fits)
                                begin
                                    avail_next      = avail_sx[31:0] - req_amt_ext[31:0];
                                    rsp_valid_next  = 1'b1;
                                    rsp_next.status = csfw_pkg::STATUS_OK;
                                end
                                else if (req.no_wait)
                                begin
                                    rsp_valid_next  = 1'b1;
                                    rsp_next.status = csfw_pkg::STATUS_WOULD_BLOCK;
                                end
                                else if (total_reg == FULL_COUNT)
                                begin
                                    rsp_valid_next  = 1'b1;
                                    rsp_next.status = csfw_pkg::STATUS_QUEUE_FULL;
                                end
                                else
                                begin
                                    // queue at the tail; reserve only for a new head
                                    load_en    = 1'b1;
                                    total_next = total_reg + ONE_COUNT;
                                    if (total_reg == '0)
                                    begin
                                        avail_next = avail_minus_req;
                                    end
                                end
                            end
                            csfw_pkg::REQ_RELEASE:
                            begin
                                if (req_amt == '0)
                                begin
                                    rsp_valid_next  = 1'b1;
                                    rsp_next.status = csfw_pkg::STATUS_BAD_VALUE;
                                end
                                else
                                begin
                                    avail_next = avail_plus_req;
                                    final_next = 1'b1;
                                    state_next = csfw_pkg::ST_GRANT;
                                end
                            end
                            csfw_pkg::REQ_CANCEL:
                            begin
                                if (total_reg == '0)
                                begin
                                    rsp_valid_next  = 1'b1;
                                    rsp_next.status = csfw_pkg::STATUS_BAD_VALUE;
                                end
                                else
                                begin
                                    scan_left_next = total_reg;
                                    found_next     = 1'b0;
                                    head_gone_next = 1'b0;
                                    first_next     = 1'b1;
                                    state_next     = csfw_pkg::ST_SCAN;
                                end
                            end
                            csfw_pkg::REQ_DELETE:
                            begin
                                state_next = csfw_pkg::ST_DELETE;
                            end
                            default:
                            begin
                                state_next = csfw_pkg::ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            // Rotate the queue once through the head, dropping the first match
            csfw_pkg::ST_SCAN:
            begin
                shift_en   = 1'b1;
                first_next = 1'b0;
                if (!found_reg && (cell_id[0] == id_reg))
                begin
                    found_next = 1'b1;
                    total_next = total_reg - ONE_COUNT;
                    if (first_reg)
                    begin
                        head_gone_next = 1'b1;
                        held_next      = cell_amt[0];
                    end
                end
                else
                begin
                    load_en  = 1'b1;
                    load_idx = IDX_W'(total_reg - ONE_COUNT);
                    load_id  = cell_id[0];
                    load_amt = cell_amt[0];
                end
                scan_left_next = scan_left_reg - ONE_COUNT;
                if (scan_left_reg == ONE_COUNT)
                begin
                    state_next = csfw_pkg::ST_SCAN_END;
                end
            end

            csfw_pkg::ST_SCAN_END:
            begin
                if (!found_reg || !head_gone_reg)
                begin
                    if (out_free)
                    begin
                        rsp_valid_next     = 1'b1;
                        rsp_next.target_id = id_reg;
                        rsp_next.status    = found_reg ? csfw_pkg::STATUS_TIMED_OUT
                                                       : csfw_pkg::STATUS_BAD_VALUE;
                        rsp_next.last      = 1'b1;
                        state_next         = csfw_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    // give back the removed head's reservation
                    avail_next = avail_plus_held;
                    state_next = csfw_pkg::ST_RESERVE;
                end
            end

            // Reserve the new head's amount
            csfw_pkg::ST_RESERVE:
            begin
                if (total_reg != '0)
                begin
                    avail_next = avail_minus_head;
                end
                state_next = csfw_pkg::ST_NOTIFY;
            end

            csfw_pkg::ST_NOTIFY:
            begin
                if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.target_id = id_reg;
                    rsp_next.status    = csfw_pkg::STATUS_TIMED_OUT;
                    rsp_next.last      = !grant_ok;
                    final_next         = 1'b0;
                    state_next         = grant_ok ? csfw_pkg::ST_GRANT : csfw_pkg::ST_IDLE;
                end
            end

            // Grant head waiters one per cycle while results are taken, then the releaser's answer after a release
            csfw_pkg::ST_GRANT:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = csfw_pkg::STATUS_OK;
                    if (grant_ok)
                    begin
                        rsp_next.target_id = cell_id[0];
                        rsp_next.last      = !final_reg && !more_grants;
                        shift_en           = 1'b1;
                        total_next         = total_reg - ONE_COUNT;
                        avail_next         = after_grant_avail;
                        if (!final_reg && !more_grants)
                        begin
                            state_next = csfw_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        rsp_next.target_id = id_reg;
                        rsp_next.last      = 1'b1;
                        state_next         = csfw_pkg::ST_IDLE;
                    end
                end
            end

            // Fail every waiter, head first
            csfw_pkg::ST_DELETE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (total_reg != '0)
                    begin
                        rsp_next.target_id = cell_id[0];
                        rsp_next.status    = csfw_pkg::STATUS_DELETED;
                        rsp_next.last      = 1'b0;
                        shift_en           = 1'b1;
                        total_next         = total_reg - ONE_COUNT;
                    end
                    else
                    begin
                        rsp_next.target_id = id_reg;
                        rsp_next.status    = csfw_pkg::STATUS_OK;
                        rsp_next.last      = 1'b1;
                        deleted_next       = 1'b1;
                        state_next         = csfw_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = csfw_pkg::ST_IDLE;
            end
        endcase

        // Register write reloads the count
        if (cfg_wr)
        begin
            init_next  = pwdata[15:0];
            avail_next = {16'b0, pwdata[15:0]};
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csfw_pkg::ST_IDLE;
            avail_reg     <= '0;
            total_reg     <= '0;
            deleted_reg   <= 1'b0;
            init_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            avail_reg     <= avail_next;
            total_reg     <= total_next;
            deleted_reg   <= deleted_next;
            init_reg      <= init_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Per-transaction payload
    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        held_reg      <= held_next;
        scan_left_reg <= scan_left_next;
        found_reg     <= found_next;
        head_gone_reg <= head_gone_next;
        first_reg     <= first_next;
        final_reg     <= final_next;
        rsp_reg       <= rsp_next;
    end

    // Register read
    assign prdata = (paddr[2] == csfw_pkg::REG_INITIAL_COUNT) ? {16'b0, init_reg} : '0;
    assign pready = 1'b1;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hdl/csfw_checker.sv
// ----------------------------------------------------------------------------
// csfw_checker
// Port-level checks of the semaphore block, bound to the top level.
// ----------------------------------------------------------------------------
module csfw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                pready,
    input logic                req_valid,
    input logic                req_ready,
    input csfw_pkg::req_item_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input csfw_pkg::rsp_item_t rsp
);

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Status stays within the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status <= csfw_pkg::STATUS_QUEUE_FULL))
        else $error("undefined status code");

    // A zero acquire is answered at once, as a single final result
    a_zero_acquire: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.req_type == csfw_pkg::REQ_ACQUIRE) &&
        (req.amount == '0)
        |=> rsp_valid && rsp.last &&
            ((rsp.status == csfw_pkg::STATUS_BAD_VALUE) ||
             (rsp.status == csfw_pkg::STATUS_DELETED)))
        else $error("zero acquire not answered");

    // Configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind counting_semaphore_fifo_waiters csfw_checker u_csfw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

>>> bench/tb_counting_semaphore_fifo_waiters.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_fifo_waiters
// Self-checking bench for the counting semaphore with a FIFO of waiters.
// A behavioral copy of the semaphore inside the bench predicts the results of
// every accepted request transaction. A checker compares each accepted result
// transaction, field by field, with the oldest prediction. Directed tests
// come first, then random traffic with random idle and stall on both sides.
// Delete runs last, since it cannot be undone.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_fifo_waiters;

    localparam int     QUEUE_DEPTH   = 16;
    localparam int     SETTLE_CYCLES = 48;
    localparam longint COUNT_MAX     = longint'(2147483647);
    localparam longint COUNT_MIN     = -longint'(2147483647) - 1;

    // DUT signals
    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                req_valid;
    logic                req_ready;
    csfw_pkg::req_item_t req;
    logic                rsp_valid;
    logic                rsp_ready;
    csfw_pkg::rsp_item_t rsp;

    // Semaphore state as the bench sees it
    longint      sem_count;
    logic [3:0]  waiter_id_q[$];
    logic [15:0] waiter_amt_q[$];
    bit          sem_deleted;

    // Results predicted but not yet seen
    csfw_pkg::rsp_item_t pending_results[$];

    int          error_count;
    bit          idle_on;
    int          stall_left;

    counting_semaphore_fifo_waiters u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Signed 32-bit clamp of the count
    function automatic longint clamp_count(input longint v);
        if (v > COUNT_MAX)
        begin
            return COUNT_MAX;
        end
        if (v < COUNT_MIN)
        begin
            return COUNT_MIN;
        end
        return v;
    endfunction

    function automatic void expect_result(input logic [3:0] id, input logic [2:0] status);
        csfw_pkg::rsp_item_t e;
        e.target_id = id;
        e.status    = status;
        e.last      = 1'b0;
        pending_results.push_back(e);
    endfunction

    // Grant head waiters while the count stays non-negative
    function automatic void grant_waiters();
        while (sem_count >= 0 && waiter_id_q.size() > 0)
        begin
            expect_result(waiter_id_q[0], csfw_pkg::STATUS_OK);
            void'(waiter_id_q.pop_front());
            void'(waiter_amt_q.pop_front());
            if (waiter_id_q.size() > 0)
            begin
                sem_count = clamp_count(sem_count - longint'(waiter_amt_q[0]));
            end
        end
    endfunction

    function automatic void predict_request(input csfw_pkg::req_item_t r);
        int     n_before;
        int     hit;
        longint held;
        n_before = pending_results.size();
        hit      = -1;
        if (sem_deleted)
        begin
            expect_result(r.requester_id, csfw_pkg::STATUS_DELETED);
        end
        else
        begin
            case (r.req_type)
                csfw_pkg::REQ_ACQUIRE:
                begin
                    if (r.amount == '0)
                    begin
                        expect_result(r.requester_id, csfw_pkg::STATUS_BAD_VALUE);
                    end
                    else if (longint'(r.amount) <= sem_count)
                    begin
                        sem_count = sem_count - longint'(r.amount);
                        expect_result(r.requester_id, csfw_pkg::STATUS_OK);
                    end
                    else if (r.no_wait)
                    begin
                        expect_result(r.requester_id, csfw_pkg::STATUS_WOULD_BLOCK);
                    end
                    else if (waiter_id_q.size() >= QUEUE_DEPTH)
                    begin
                        expect_result(r.requester_id, csfw_pkg::STATUS_QUEUE_FULL);
                    end
                    else
                    begin
                        // only the head's amount is held against the count
                        if (waiter_id_q.size() == 0)
                        begin
                            sem_count = clamp_count(sem_count - longint'(r.amount));
                        end
                        waiter_id_q.push_back(r.requester_id);
                        waiter_amt_q.push_back(r.amount);
                    end
                end
                csfw_pkg::REQ_RELEASE:
                begin
                    if (r.amount == '0)
                    begin
                        expect_result(r.requester_id, csfw_pkg::STATUS_BAD_VALUE);
                    end
                    else
                    begin
                        sem_count = clamp_count(sem_count + longint'(r.amount));
                        grant_waiters();
                        expect_result(r.requester_id, csfw_pkg::STATUS_OK);
                    end
                end
                csfw_pkg::REQ_CANCEL:
                begin
                    // nearest match to the head wins
                    for (int i = 0; i < waiter_id_q.size(); i++)
                    begin
                        if (hit < 0 && waiter_id_q[i] == r.requester_id)
                        begin
                            hit = i;
                        end
                    end
                    if (hit < 0)
                    begin
                        expect_result(r.requester_id, csfw_pkg::STATUS_BAD_VALUE);
                    end
                    else
                    begin
                        held = longint'(waiter_amt_q[hit]);
                        expect_result(r.requester_id, csfw_pkg::STATUS_TIMED_OUT);
                        waiter_id_q.delete(hit);
                        waiter_amt_q.delete(hit);
                        if (hit == 0)
                        begin
                            sem_count = clamp_count(sem_count + held);
                            if (waiter_id_q.size() > 0)
                            begin
                                sem_count = clamp_count(sem_count
                                                        - longint'(waiter_amt_q[0]));
                            end
                            grant_waiters();
                        end
                    end
                end
                default:
                begin
                    foreach (waiter_id_q[i])
                    begin
                        expect_result(waiter_id_q[i], csfw_pkg::STATUS_DELETED);
                    end
                    waiter_id_q.delete();
                    waiter_amt_q.delete();
                    sem_deleted = 1'b1;
                    expect_result(r.requester_id, csfw_pkg::STATUS_OK);
                end
            endcase
        end
        if (pending_results.size() > n_before)
        begin
            pending_results[pending_results.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none, some short, a few long
    function automatic int pick_idle_len();
        int k;
        if (!idle_on)
        begin
            return 0;
        end
        k = $urandom_range(0, 99);
        if (k < 55)
        begin
            return 0;
        end
        if (k < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic csfw_pkg::req_item_t make_req(input logic [1:0] kind,
                                                     input logic [3:0] id,
                                                     input logic [15:0] amt,
                                                     input logic nw);
        csfw_pkg::req_item_t r;
        r.req_type     = kind;
        r.requester_id = id;
        r.amount       = amt;
        r.no_wait      = nw;
        return r;
    endfunction

    // One request transaction; valid stays up when the next one follows at once
    task automatic send_request(input csfw_pkg::req_item_t r);
        int gap;
        gap = pick_idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        predict_request(r);
    endtask

    // Hold off requests until every predicted result is back and the block idles
    task automatic wait_for_quiet();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of initial_count: setup, then access
    task automatic write_initial_count(input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {csfw_pkg::REG_INITIAL_COUNT, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sem_count = longint'(value);
    endtask

    // ------------------------------------------------------------------------
    // Result checker and result-side stall
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_checker
        csfw_pkg::rsp_item_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: target_id %0d status %0d last %0d",
                       rsp.target_id, rsp.status, rsp.last);
                error_count++;
            end
            else
            begin
                exp_rsp = pending_results.pop_front();
                if (rsp.target_id !== exp_rsp.target_id)
                begin
                    $error("target_id: expected %0d, got %0d",
                           exp_rsp.target_id, rsp.target_id);
                    error_count++;
                end
                if (rsp.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
                    error_count++;
                end
                if (rsp.last !== exp_rsp.last)
                begin
                    $error("last: expected %0d, got %0d", exp_rsp.last, rsp.last);
                    error_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_idle_len();
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Grants, rejects and would-block with no waiters
    task automatic test_immediate_grants();
        idle_on = 1'b1;
        write_initial_count(16'hFFFF);
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd15, 16'h0000, 1'b0));
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd0, 16'hFFFF, 1'b1));
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd3, 16'h0001, 1'b1));
        send_request(make_req(csfw_pkg::REQ_RELEASE, 4'd4, 16'h0000, 1'b0));
        send_request(make_req(csfw_pkg::REQ_RELEASE, 4'd5, 16'hFFFF, 1'b1));
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd6, 16'h8000, 1'b0));
        wait_for_quiet();
    endtask

    // Queueing, cancel of head and non-head, duplicate ids, unknown cancel
    task automatic test_waiter_queue();
        idle_on = 1'b0;
        write_initial_count(16'd3);
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd1, 16'd5, 1'b0));
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd2, 16'd2, 1'b0));
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd3, 16'hFFFF, 1'b0));
        send_request(make_req(csfw_pkg::REQ_CANCEL, 4'd9, 16'd0, 1'b0));
        send_request(make_req(csfw_pkg::REQ_CANCEL, 4'd2, 16'd7, 1'b1));
        send_request(make_req(csfw_pkg::REQ_RELEASE, 4'd4, 16'd2, 1'b0));
        send_request(make_req(csfw_pkg::REQ_CANCEL, 4'd3, 16'd0, 1'b0));
        // same id queued twice: the one nearer the head goes
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd5, 16'd10, 1'b0));
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd5, 16'd1, 1'b0));
        send_request(make_req(csfw_pkg::REQ_CANCEL, 4'd5, 16'd0, 1'b0));
        send_request(make_req(csfw_pkg::REQ_RELEASE, 4'd6, 16'd1, 1'b0));
        wait_for_quiet();
    endtask

    // Fill the queue, overflow it, then release everyone at once
    task automatic test_queue_full();
        idle_on = 1'b1;
        write_initial_count(16'd0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'(i), 16'd1, 1'b0));
        end
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd15, 16'd1, 1'b0));
        send_request(make_req(csfw_pkg::REQ_RELEASE, 4'd0, 16'hFFFF, 1'b0));
        wait_for_quiet();
    endtask

    // Reload the count while waiters sit in the queue: no grants until a release
    task automatic test_reload_with_waiters();
        idle_on = 1'b0;
        write_initial_count(16'd0);
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd7, 16'd100, 1'b0));
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd8, 16'd50, 1'b0));
        wait_for_quiet();
        write_initial_count(16'h2000);
        send_request(make_req(csfw_pkg::REQ_RELEASE, 4'd9, 16'd1, 1'b0));
        wait_for_quiet();
    endtask

    // Random mix of acquire, release and cancel over several count settings
    task automatic test_random_traffic(input int n_items);
        int          k;
        logic [1:0]  kind;
        logic [3:0]  id;
        logic [15:0] amt;
        logic        nw;
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_on = (phase != 1);
            case (phase)
                0:       write_initial_count(16'd0);
                1:       write_initial_count(16'hFFFF);
                2:       write_initial_count(16'($urandom_range(1, 40)));
                default: write_initial_count(16'($urandom()));
            endcase
            for (int n = 0; n < n_items / 4; n++)
            begin
                k = $urandom_range(0, 99);
                if (k < 45)
                begin
                    kind = csfw_pkg::REQ_ACQUIRE;
                end
                else if (k < 75)
                begin
                    kind = csfw_pkg::REQ_RELEASE;
                end
                else
                begin
                    kind = csfw_pkg::REQ_CANCEL;
                end
                id = 4'($urandom());
                if (kind == csfw_pkg::REQ_CANCEL && waiter_id_q.size() > 0
                    && $urandom_range(0, 3) != 0)
                begin
                    id = waiter_id_q[$urandom_range(0, waiter_id_q.size() - 1)];
                end
                k = $urandom_range(0, 99);
                if (k < 5)
                begin
                    amt = '0;
                end
                else if (k < 75)
                begin
                    amt = 16'($urandom_range(1, 16));
                end
                else if (k < 90)
                begin
                    amt = 16'($urandom_range(1, 1000));
                end
                else
                begin
                    amt = 16'($urandom());
                end
                nw = ($urandom_range(0, 3) == 0);
                send_request(make_req(kind, id, amt, nw));
                // occasional full drain before going on
                if ($urandom_range(0, 49) == 0)
                begin
                    wait_for_quiet();
                end
            end
            wait_for_quiet();
        end
    endtask

    // Delete with waiters queued, then random requests of any kind afterwards
    task automatic test_delete();
        idle_on = 1'b1;
        write_initial_count(16'd0);
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd2, 16'd4, 1'b0));
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd11, 16'd9, 1'b0));
        send_request(make_req(csfw_pkg::REQ_ACQUIRE, 4'd2, 16'd1, 1'b0));
        send_request(make_req(csfw_pkg::REQ_DELETE, 4'd13, 16'($urandom()),
                              1'($urandom())));
        for (int n = 0; n < 12; n++)
        begin
            send_request(make_req(2'($urandom()), 4'($urandom()), 16'($urandom()),
                                  1'($urandom())));
        end
        wait_for_quiet();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        req_valid   = 1'b0;
        req         = '0;
        sem_count   = 0;
        sem_deleted = 1'b0;
        idle_on     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        test_immediate_grants();
        test_waiter_queue();
        test_queue_full();
        test_reload_with_waiters();
        test_random_traffic(160);
        test_delete();

        if (error_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
